@@ sv/laser_scan_segmenter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Laser scan segmenter assertion macros
// Shorthand for clocked assertions sampled on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LASER_SCAN_SEGMENTER_UNIT_MACROS_SVH
`define LASER_SCAN_SEGMENTER_UNIT_MACROS_SVH

// property must hold at every edge out of reset
`define LSS_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("laser scan segmenter: property violated");

// condition must never be seen out of reset
`define LSS_ASSERT_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("laser scan segmenter: forbidden condition seen");

`endif

@@ sv/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// Laser scan segmenter package
// Shared widths, register indexes, controller/datapath bundles, CORDIC table.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

	localparam int RANGE_W    = 16;
	localparam int ANGLE_W    = 16;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int COORD_W    = 17;
	localparam int IDX_OUT_W  = 11;
	localparam int SEG_W      = 11;
	localparam int CDC_W      = 24;
	localparam int Z_W        = 32;
	localparam int STEP_W     = 5;
	localparam int SQ_W       = 34;
	localparam int OUT_DATA_W = 2 * COORD_W + IDX_OUT_W + SEG_W;

	// inverse CORDIC gain, Q.16
	localparam logic [15:0] KINV_Q16 = 16'd39797;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_SQ    = 3'd4;

	typedef struct packed {
		logic accept;
		logic cordic_init;
		logic cordic_step;
		logic round;
		logic sq_x;
		logic sq_y;
		logic commit;
		logic flush;
	} lss_cmd_t;

	typedef struct packed {
		logic in_keep;
		logic step_last;
		logic out_free;
		logic commit_emits;
		logic flush_emits;
	} lss_status_t;

	// atan(2^-i), 2^32 per turn
	function automatic logic [Z_W-1:0] atan_val(input logic [STEP_W-1:0] i);
		logic [Z_W-1:0] v;
		unique case (i)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ sv/laser_scan_segmenter_unit.sv @@
// ----------------------------------------------------------------------------
// Laser scan segmenter
// Range gate, polar to Cartesian by CORDIC and breakpoint segmentation.
// ----------------------------------------------------------------------------
// Beams enter one transaction at a time; tuser high marks an end of scan. A
// beam outside [range_min, range_max] is only accepted. A kept beam passes
// through the single shared CORDIC rotator doing one micro-rotation a cycle,
// followed by rounding, two squared-difference steps on two multipliers and
// the commit, which waits while a point goes out and the output register is
// still full. An end of scan is accepted and then flushed, with the same
// wait. Points leave one kept beam late, so a point appears only once its
// successor or the end of scan is known; the output register holds a finished
// point while the next beam is taken. Single-point segments are not emitted.
`default_nettype none

module laser_scan_segmenter_unit
	import lss_pkg::*;
#(
	parameter int MAX_BEAMS    = 2048,
	parameter int CORDIC_STEPS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_W-1:0]      cfg_data,
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire  [RANGE_W-1:0]    s_axis_tdata,  // range[15:0]
	input  wire                   s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	// pos_x[16:0], pos_y[33:17], kept_index[44:34], segment_number[55:45]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast   // segment_end
);

	lss_cmd_t    cmd;
	lss_status_t status;

	lss_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tready (s_axis_tready),
		.cmd           (cmd),
		.status        (status)
	);

	lss_datapath #(
		.MAX_BEAMS    (MAX_BEAMS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

`default_nettype wire

@@ sv/lss_ctrl.sv @@
// ----------------------------------------------------------------------------
// Laser scan segmenter controller
// Sequences accept, CORDIC, distance check and commit/flush of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_ctrl
	import lss_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tuser,
	output logic        s_axis_tready,
	output lss_cmd_t    cmd,
	input  lss_status_t status
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_INIT   = 3'd1;
	localparam logic [2:0] ST_ITER   = 3'd2;
	localparam logic [2:0] ST_ROUND  = 3'd3;
	localparam logic [2:0] ST_SQX    = 3'd4;
	localparam logic [2:0] ST_SQY    = 3'd5;
	localparam logic [2:0] ST_DECIDE = 3'd6;
	localparam logic [2:0] ST_FLUSH  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.accept = 1'b1;
					if (s_axis_tuser) begin
						state_d = ST_FLUSH;
					end else if (status.in_keep) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.cordic_init = 1'b1;
				state_d         = ST_ITER;
			end
			ST_ITER: begin
				cmd.cordic_step = 1'b1;
				if (status.step_last) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_SQX;
			end
			ST_SQX: begin
				cmd.sq_x = 1'b1;
				state_d  = ST_SQY;
			end
			ST_SQY: begin
				cmd.sq_y = 1'b1;
				state_d  = ST_DECIDE;
			end
			ST_DECIDE: begin
				// wait only if a point goes out and the output register is still full
				if (!status.commit_emits || status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!status.flush_emits || status.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/lss_datapath.sv @@
// ----------------------------------------------------------------------------
// Laser scan segmenter datapath
// Config registers, range gate, shared CORDIC rotator, squared-distance unit,
// scan state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_datapath
	import lss_pkg::*;
#(
	parameter int MAX_BEAMS    = 2048,
	parameter int CORDIC_STEPS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_W-1:0]      cfg_data,
	input  wire  [RANGE_W-1:0]    s_axis_tdata,
	input  wire                   s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	input  lss_cmd_t              cmd,
	output lss_status_t           status
);

	localparam int CNT_W = $clog2(MAX_BEAMS);
	localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MAX_BEAMS - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
	localparam logic signed [CDC_W-1:0] SAT_HI = CDC_W'(65535);
	localparam logic signed [CDC_W-1:0] SAT_LO = CDC_W'(-65536);

	// config
	logic [RANGE_W-1:0] range_min_q, range_max_q;
	logic [ANGLE_W-1:0] angle_start_q, angle_step_q;
	logic [CFG_W-1:0]   split_sq_q;

	// current item
	logic [RANGE_W-1:0] range_q;
	logic [ANGLE_W-1:0] ang_q;

	// rotator
	logic signed [CDC_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]   z_q;
	logic                    flip_q;
	logic [STEP_W-1:0]       step_q;

	logic signed [COORD_W-1:0] px_q, py_q;
	logic [SQ_W-1:0]           sqx_q, sqy_q;

	// scan state
	logic [CNT_W-1:0]          raw_cnt_q, kept_cnt_q, held_idx_q;
	logic signed [COORD_W-1:0] held_x_q, held_y_q;
	logic                      held_valid_q;
	logic [1:0]                run_q;
	logic [SEG_W-1:0]          seg_q;

	logic out_valid_q;

	// combinational
	logic                      keep;
	logic [31:0]               ang_prod;
	logic [31:0]               kinv_prod;
	logic [ANGLE_W-1:0]        ang_fold;
	logic                      fold_flip;
	logic signed [CDC_W-1:0]   xs, ys;
	logic signed [Z_W-1:0]     atan_z;
	logic signed [CDC_W-1:0]   vx, vy;
	logic signed [COORD_W:0]   dx, dy;
	logic signed [2*COORD_W+1:0] dx_sq, dy_sq;
	logic [SQ_W:0]             dsq;
	logic                      brk;
	logic                      commit_emits, flush_emits;
	logic                      load_out;

	function automatic logic signed [COORD_W-1:0] sat_q10(input logic signed [CDC_W-1:0] v);
		logic signed [CDC_W-1:0] q;
		logic signed [COORD_W-1:0] r;
		q = (v + CDC_W'(8)) >>> 4;
		if (q > SAT_HI) begin
			r = COORD_W'(SAT_HI);
		end else if (q < SAT_LO) begin
			r = COORD_W'(SAT_LO);
		end else begin
			r = COORD_W'(q);
		end
		return r;
	endfunction

	assign keep      = (s_axis_tdata >= range_min_q) && (s_axis_tdata <= range_max_q);
	assign ang_prod  = angle_step_q * 16'(raw_cnt_q);
	assign kinv_prod = range_q * KINV_Q16;

	// fold into [-quarter, quarter): a half-turn shift is a flip of the top bit
	assign fold_flip = ang_q[15] ^ ang_q[14];
	assign ang_fold  = fold_flip ? {~ang_q[15], ang_q[14:0]} : ang_q;

	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign atan_z = $signed(atan_val(step_q));

	// px = -x and py = y of the angle with the fold undone
	assign vx = flip_q ? x_q : -x_q;
	assign vy = flip_q ? -y_q : y_q;

	assign dx    = {px_q[COORD_W-1], px_q} - {held_x_q[COORD_W-1], held_x_q};
	assign dy    = {py_q[COORD_W-1], py_q} - {held_y_q[COORD_W-1], held_y_q};
	assign dx_sq = dx * dx;
	assign dy_sq = dy * dy;

	assign dsq = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign brk = dsq > (SQ_W+1)'(split_sq_q);

	assign commit_emits = held_valid_q && (!brk || run_q[1]);
	assign flush_emits  = held_valid_q && run_q[1];
	assign load_out     = (cmd.commit && commit_emits) || (cmd.flush && flush_emits);

	assign status.in_keep      = keep;
	assign status.step_last    = (step_q == STEP_LAST);
	assign status.out_free     = !out_valid_q || m_axis_tready;
	assign status.commit_emits = commit_emits;
	assign status.flush_emits  = flush_emits;

	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q   <= '0;
			range_max_q   <= 16'hFFFF;
			angle_start_q <= 16'd16384;
			angle_step_q  <= 16'd32;
			split_sq_q    <= 32'd50751;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_MIN:   range_min_q   <= cfg_data[RANGE_W-1:0];
				REG_RANGE_MAX:   range_max_q   <= cfg_data[RANGE_W-1:0];
				REG_ANGLE_START: angle_start_q <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data[ANGLE_W-1:0];
				REG_SPLIT_SQ:    split_sq_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// item payload and rotator
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			range_q <= s_axis_tdata;
			ang_q   <= angle_start_q + ang_prod[ANGLE_W-1:0];
		end
		if (cmd.cordic_init) begin
			x_q    <= CDC_W'(kinv_prod[31:12]);
			y_q    <= '0;
			z_q    <= {ang_fold, 16'h0000};
			flip_q <= fold_flip;
			step_q <= '0;
		end else if (cmd.cordic_step) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_z;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_z;
			end
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.round) begin
			px_q <= sat_q10(vx);
			py_q <= sat_q10(vy);
		end
		if (cmd.sq_x) begin
			sqx_q <= dx_sq[SQ_W-1:0];
		end
		if (cmd.sq_y) begin
			sqy_q <= dy_sq[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_cnt_q    <= '0;
			kept_cnt_q   <= '0;
			held_idx_q   <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			held_valid_q <= 1'b0;
			run_q        <= '0;
			seg_q        <= '0;
		end else begin
			if (cmd.accept && !s_axis_tuser) begin
				raw_cnt_q <= (raw_cnt_q == CNT_LAST) ? '0 : raw_cnt_q + CNT_W'(1);
			end
			if (cmd.flush) begin
				raw_cnt_q    <= '0;
				kept_cnt_q   <= '0;
				held_idx_q   <= '0;
				held_x_q     <= '0;
				held_y_q     <= '0;
				held_valid_q <= 1'b0;
				run_q        <= '0;
				seg_q        <= '0;
			end else if (cmd.commit) begin
				if (held_valid_q) begin
					if (brk) begin
						if (run_q[1]) begin
							seg_q <= seg_q + SEG_W'(1);
						end
						run_q <= 2'd1;
					end else begin
						run_q <= run_q[1] ? 2'd2 : run_q + 2'd1;
					end
				end else begin
					run_q <= 2'd1;
				end
				held_x_q     <= px_q;
				held_y_q     <= py_q;
				held_idx_q   <= kept_cnt_q;
				held_valid_q <= 1'b1;
				kept_cnt_q   <= (kept_cnt_q == CNT_LAST) ? '0 : kept_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_axis_tdata <= {seg_q, IDX_OUT_W'(held_idx_q), held_y_q, held_x_q};
			// a flush always closes the segment
			m_axis_tlast <= cmd.flush | brk;
		end
	end

endmodule

`default_nettype wire

@@ sv/lss_checker.sv @@
// ----------------------------------------------------------------------------
// Laser scan segmenter port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "laser_scan_segmenter_unit_macros.svh"

module lss_checker
	import lss_pkg::*;
(
	input wire                  clk,
	input wire                  arst_n,
	input wire                  cfg_we,
	input wire [CFG_IDX_W-1:0]  cfg_index,
	input wire [CFG_W-1:0]      cfg_data,
	input wire                  s_axis_tvalid,
	input wire                  s_axis_tready,
	input wire [RANGE_W-1:0]    s_axis_tdata,
	input wire                  s_axis_tuser,
	input wire                  m_axis_tvalid,
	input wire                  m_axis_tready,
	input wire [OUT_DATA_W-1:0] m_axis_tdata,
	input wire                  m_axis_tlast
);

	logic in_xact;

	assign in_xact = s_axis_tvalid && s_axis_tready;

	// a stalled result transaction keeps its payload
	`LSS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// an end of scan is always followed by busy on the input side
	`LSS_ASSERT(a_flush_busy, in_xact && s_axis_tuser |=> !s_axis_tready)

	// a new result is only produced from a busy cycle
	`LSS_ASSERT_NEVER(a_out_from_idle, m_axis_tvalid && !$past(m_axis_tvalid) && $past(s_axis_tready))

	// the input side only goes busy after taking a transaction
	`LSS_ASSERT(a_busy_after_xact, $fell(s_axis_tready) |-> $past(s_axis_tvalid))

	logic unused_ok;
	assign unused_ok = cfg_we ^ (|cfg_index) ^ (|cfg_data) ^ (|s_axis_tdata);

endmodule

bind laser_scan_segmenter_unit lss_checker u_lss_checker (.*);

`default_nettype wire
